FILE: design/fzal_pkg.sv
// Shared constants, types and arithmetic helpers for the fuzzy alert inference block.
// Holds set breakpoints, reciprocal divider constants and the rule table.
// Depends on nothing; every other design file imports it.
package fzal_pkg;

  localparam int SL_RAMPS = 6;
  localparam int VL_RAMPS = 4;
  localparam int LV_RAMPS = 4;
  localparam int SL_SETS  = 4;
  localparam int VL_SETS  = 3;
  localparam int LV_SETS  = 3;
  localparam int ALERTS   = 4;

  // Breakpoints in input units (slope and level carry 8 fraction bits)
  localparam logic [20:0] SL_A  = 21'(8 * 256);
  localparam logic [20:0] SL_B  = 21'(11 * 256);
  localparam logic [20:0] SL_C  = 21'(15 * 256);
  localparam logic [20:0] SL_D  = 21'(18 * 256);
  localparam logic [20:0] SL_E  = 21'(32 * 256);
  localparam logic [20:0] SL_F  = 21'(35 * 256);
  localparam logic [20:0] SL_W  = 21'(3 * 256);

  localparam logic [20:0] LV_A  = 21'(10 * 256);
  localparam logic [20:0] LV_B  = 21'(20 * 256);
  localparam logic [20:0] LV_C  = 21'(30 * 256);
  localparam logic [20:0] LV_W  = 21'(10 * 256);

  localparam logic [20:0] VOL_A = 21'd700000;
  localparam logic [20:0] VOL_B = 21'd950000;
  localparam logic [20:0] VOL_C = 21'd1200000;
  localparam logic [20:0] VOL_W = 21'd250000;

  // Ramp quotients: slope n/3, level n/10, volume 32n/31250.
  // Reciprocal estimates are low by at most one; a later step corrects.
  localparam logic [8:0]  SL_RECIP  = 9'd341;      // floor(2^10 / 3)
  localparam logic [8:0]  LV_RECIP  = 9'd409;      // floor(2^12 / 10)
  localparam logic [23:0] VOL_RECIP = 24'd8796093; // floor(2^38 / 31250)
  localparam logic [1:0]  SL_DIV    = 2'd3;
  localparam logic [3:0]  LV_DIV    = 4'd10;
  localparam logic [14:0] VOL_DIV   = 15'd31250;

  // Alert codes
  localparam logic [1:0] ALERT_FOUR  = 2'd0;
  localparam logic [1:0] ALERT_THREE = 2'd1;
  localparam logic [1:0] ALERT_TWO   = 2'd2;
  localparam logic [1:0] ALERT_ONE   = 2'd3;

  // Alert fed by each rule, indexed [slope set][volume set][level set]
  localparam logic [1:0] RULE_ALERT [4][3][3] = '{
    '{ '{ALERT_FOUR,  ALERT_THREE, ALERT_TWO},
       '{ALERT_FOUR,  ALERT_THREE, ALERT_TWO},
       '{ALERT_THREE, ALERT_THREE, ALERT_TWO} },
    '{ '{ALERT_FOUR,  ALERT_THREE, ALERT_TWO},
       '{ALERT_THREE, ALERT_THREE, ALERT_TWO},
       '{ALERT_THREE, ALERT_TWO,   ALERT_TWO} },
    '{ '{ALERT_THREE, ALERT_TWO,   ALERT_TWO},
       '{ALERT_THREE, ALERT_TWO,   ALERT_ONE},
       '{ALERT_THREE, ALERT_TWO,   ALERT_ONE} },
    '{ '{ALERT_TWO,   ALERT_ONE,   ALERT_ONE},
       '{ALERT_TWO,   ALERT_ONE,   ALERT_ONE},
       '{ALERT_ONE,   ALERT_ONE,   ALERT_ONE} }
  };

  typedef struct packed {
    logic [SL_SETS-1:0][8:0] ms;
    logic [VL_SETS-1:0][8:0] mv;
    logic [LV_SETS-1:0][8:0] mh;
  } member_t;

  // Rising ramp offset, clamped to [0, w]
  function automatic logic [17:0] ramp_rise(input logic [20:0] x, input logic [20:0] a,
                                            input logic [20:0] w);
    logic [20:0] b;
    b = a + w;
    if (x <= a) ramp_rise = '0;
    else if (x >= b) ramp_rise = w[17:0];
    else ramp_rise = 18'(x - a);
  endfunction

  // Falling ramp offset, clamped to [0, w]
  function automatic logic [17:0] ramp_fall(input logic [20:0] x, input logic [20:0] d,
                                            input logic [20:0] w);
    logic [20:0] c;
    c = d - w;
    if (x >= d) ramp_fall = '0;
    else if (x <= c) ramp_fall = w[17:0];
    else ramp_fall = 18'(d - x);
  endfunction

  function automatic logic [8:0] est_slope(input logic [9:0] n);
    logic [18:0] p;
    p = 19'(n) * 19'(SL_RECIP);
    est_slope = p[18:10];
  endfunction

  function automatic logic [8:0] est_level(input logic [11:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'(LV_RECIP);
    est_level = p[20:12];
  endfunction

  function automatic logic [8:0] est_vol(input logic [17:0] n);
    logic [46:0] p;
    p = 47'({n, 5'b0}) * 47'(VOL_RECIP);
    est_vol = p[46:38];
  endfunction

  function automatic logic [8:0] fix_slope(input logic [9:0] n, input logic [8:0] q0);
    logic [10:0] t;
    logic [10:0] r;
    t = 11'(q0) * 11'(SL_DIV);
    r = 11'(n) - t;
    fix_slope = (r >= 11'(SL_DIV)) ? 9'(q0 + 9'd1) : q0;
  endfunction

  function automatic logic [8:0] fix_level(input logic [11:0] n, input logic [8:0] q0);
    logic [12:0] t;
    logic [12:0] r;
    t = 13'(q0) * 13'(LV_DIV);
    r = 13'(n) - t;
    fix_level = (r >= 13'(LV_DIV)) ? 9'(q0 + 9'd1) : q0;
  endfunction

  function automatic logic [8:0] fix_vol(input logic [17:0] n, input logic [8:0] q0);
    logic [23:0] t;
    logic [23:0] r;
    t = 24'(q0) * 24'(VOL_DIV);
    r = 24'({n, 5'b0}) - t;
    fix_vol = (r >= 24'(VOL_DIV)) ? 9'(q0 + 9'd1) : q0;
  endfunction

  function automatic logic [8:0] min2(input logic [8:0] a, input logic [8:0] b);
    min2 = (a < b) ? a : b;
  endfunction

endpackage

FILE: design/fzal_fuzz.sv
// Fuzzification pipeline: three register stages from raw readings to memberships.
// Stage 1 clamps ramp offsets, stage 2 multiplies by reciprocals, stage 3 corrects.
// Depends on fzal_pkg.
module fzal_fuzz (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [13:0]      slope,
  input  logic [20:0]      water_volume,
  input  logic [13:0]      water_level,
  output logic             out_valid,
  input  logic             out_ready,
  output fzal_pkg::member_t member
);
  import fzal_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [20:0] slope_x, level_x;

  logic [9:0]  sl_n_next [SL_RAMPS];
  logic [17:0] vl_n_next [VL_RAMPS];
  logic [11:0] lv_n_next [LV_RAMPS];

  logic [9:0]  sl_n1 [SL_RAMPS];
  logic [17:0] vl_n1 [VL_RAMPS];
  logic [11:0] lv_n1 [LV_RAMPS];

  logic [9:0]  sl_n2 [SL_RAMPS];
  logic [17:0] vl_n2 [VL_RAMPS];
  logic [11:0] lv_n2 [LV_RAMPS];
  logic [8:0]  sl_q2 [SL_RAMPS];
  logic [8:0]  vl_q2 [VL_RAMPS];
  logic [8:0]  lv_q2 [LV_RAMPS];

  logic [8:0]  sl_m [SL_RAMPS];
  logic [8:0]  vl_m [VL_RAMPS];
  logic [8:0]  lv_m [LV_RAMPS];
  member_t     member_next;

  assign slope_x = 21'(slope);
  assign level_x = 21'(water_level);

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  // Ramp order: fall, rise, fall, rise ... matching the set order
  always_comb begin
    sl_n_next[0] = 10'(ramp_fall(slope_x, SL_B, SL_W));
    sl_n_next[1] = 10'(ramp_rise(slope_x, SL_A, SL_W));
    sl_n_next[2] = 10'(ramp_fall(slope_x, SL_D, SL_W));
    sl_n_next[3] = 10'(ramp_rise(slope_x, SL_C, SL_W));
    sl_n_next[4] = 10'(ramp_fall(slope_x, SL_F, SL_W));
    sl_n_next[5] = 10'(ramp_rise(slope_x, SL_E, SL_W));
    vl_n_next[0] = ramp_fall(water_volume, VOL_B, VOL_W);
    vl_n_next[1] = ramp_rise(water_volume, VOL_A, VOL_W);
    vl_n_next[2] = ramp_fall(water_volume, VOL_C, VOL_W);
    vl_n_next[3] = ramp_rise(water_volume, VOL_B, VOL_W);
    lv_n_next[0] = 12'(ramp_fall(level_x, LV_B, LV_W));
    lv_n_next[1] = 12'(ramp_rise(level_x, LV_A, LV_W));
    lv_n_next[2] = 12'(ramp_fall(level_x, LV_C, LV_W));
    lv_n_next[3] = 12'(ramp_rise(level_x, LV_B, LV_W));
  end

  always_comb begin
    for (int i = 0; i < SL_RAMPS; i++) sl_m[i] = fix_slope(sl_n2[i], sl_q2[i]);
    for (int i = 0; i < VL_RAMPS; i++) vl_m[i] = fix_vol(vl_n2[i], vl_q2[i]);
    for (int i = 0; i < LV_RAMPS; i++) lv_m[i] = fix_level(lv_n2[i], lv_q2[i]);
    member_next.ms[0] = sl_m[0];
    member_next.ms[1] = min2(sl_m[1], sl_m[2]);
    member_next.ms[2] = min2(sl_m[3], sl_m[4]);
    member_next.ms[3] = sl_m[5];
    member_next.mv[0] = vl_m[0];
    member_next.mv[1] = min2(vl_m[1], vl_m[2]);
    member_next.mv[2] = vl_m[3];
    member_next.mh[0] = lv_m[0];
    member_next.mh[1] = min2(lv_m[1], lv_m[2]);
    member_next.mh[2] = lv_m[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sl_n1 <= sl_n_next;
      vl_n1 <= vl_n_next;
      lv_n1 <= lv_n_next;
    end
    if (rdy2 && v1) begin
      for (int i = 0; i < SL_RAMPS; i++) begin
        sl_n2[i] <= sl_n1[i];
        sl_q2[i] <= est_slope(sl_n1[i]);
      end
      for (int i = 0; i < VL_RAMPS; i++) begin
        vl_n2[i] <= vl_n1[i];
        vl_q2[i] <= est_vol(vl_n1[i]);
      end
      for (int i = 0; i < LV_RAMPS; i++) begin
        lv_n2[i] <= lv_n1[i];
        lv_q2[i] <= est_level(lv_n1[i]);
      end
    end
    if (rdy3 && v2) begin
      member <= member_next;
    end
  end

endmodule

FILE: design/fzal_rules.sv
// Rule evaluation pipeline: rule minimums, per-row maximums, final alert maximums.
// Three register stages; the last one is the result register.
// Depends on fzal_pkg.
module fzal_rules (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fzal_pkg::member_t             member,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fzal_pkg::ALERTS-1:0][8:0] strength
);
  import fzal_pkg::*;

  logic v4, v5, v6;
  logic rdy4, rdy5, rdy6;

  logic [8:0] w4   [SL_SETS][VL_SETS][LV_SETS];
  logic [8:0] row5 [SL_SETS][ALERTS];
  logic [8:0] row_next [SL_SETS][ALERTS];
  logic [ALERTS-1:0][8:0] strength_next;

  assign rdy6      = !v6 || out_ready;
  assign rdy5      = !v5 || rdy6;
  assign rdy4      = !v4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v6;

  // Max over the nine rules of one slope set, per alert
  always_comb begin
    for (int i = 0; i < SL_SETS; i++) begin
      for (int a = 0; a < ALERTS; a++) begin
        row_next[i][a] = '0;
        for (int j = 0; j < VL_SETS; j++) begin
          for (int k = 0; k < LV_SETS; k++) begin
            if (RULE_ALERT[i][j][k] == 2'(a) && w4[i][j][k] > row_next[i][a])
              row_next[i][a] = w4[i][j][k];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < ALERTS; a++) begin
      strength_next[a] = '0;
      for (int i = 0; i < SL_SETS; i++) begin
        if (row5[i][a] > strength_next[a]) strength_next[a] = row5[i][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      for (int i = 0; i < SL_SETS; i++)
        for (int j = 0; j < VL_SETS; j++)
          for (int k = 0; k < LV_SETS; k++)
            w4[i][j][k] <= min2(member.ms[i], min2(member.mv[j], member.mh[k]));
    end
    if (rdy5 && v4) begin
      row5 <= row_next;
    end
    if (rdy6 && v5) begin
      strength <= strength_next;
    end
  end

endmodule

FILE: design/fuzzy_three_input_alert_inference.sv
// Top level of the fuzzy alert inference block (Mamdani min/max).
// Connects the fuzzification pipeline to the rule evaluation pipeline.
// Depends on fzal_pkg, fzal_fuzz and fzal_rules.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) carries one request per
//   sensor sample: slope, water volume and water level. The master channel
//   (m_tvalid/m_tready/m_tdata) returns exactly one result per request: the
//   four alert strengths in Q1.8 (0 to 256), in request order.
//   The datapath is six register stages: ramp clamp, reciprocal multiply,
//   quotient correction with set merge, rule minimum, per-row maximum and
//   the final maximum, which is the output register. Throughput is one
//   request per cycle while m_tready is held high.
//   Each stage carries its own valid bit and advances whenever its successor
//   has room, so bubbles close up under a stall. When the receiver holds
//   m_tready low, the result stays put and the pipeline keeps filling; after
//   six requests are held s_tready drops until the result is taken.
//   Synchronous active-high rst empties all stages; no result is pending
//   after reset and the block has no other state.
module fuzzy_three_input_alert_inference (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // [13:0] slope, [34:14] water_volume, [48:35] water_level
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // [8:0] alert_four_strength, [17:9] alert_three_strength,
                                // [26:18] alert_two_strength, [35:27] alert_one_strength
);
  import fzal_pkg::*;

  logic                   mid_valid;
  logic                   mid_ready;
  member_t                member;
  logic [ALERTS-1:0][8:0] strength;

  // Stages 1-3: readings to memberships
  fzal_fuzz u_fuzz (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .slope        (s_tdata[13:0]),
    .water_volume (s_tdata[34:14]),
    .water_level  (s_tdata[48:35]),
    .out_valid    (mid_valid),
    .out_ready    (mid_ready),
    .member       (member)
  );

  // Stages 4-6: rule firing and alert aggregation
  fzal_rules u_rules (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .member    (member),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .strength  (strength)
  );

  // Pack the strengths, alert level four lowest; pad to whole bytes
  assign m_tdata = {4'b0, strength[ALERT_ONE], strength[ALERT_TWO],
                    strength[ALERT_THREE], strength[ALERT_FOUR]};

`ifndef SYNTHESIS
  // Strengths are Q1.8 and never exceed full membership
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] <= 9'd256) && (m_tdata[17:9] <= 9'd256) &&
                 (m_tdata[26:18] <= 9'd256) && (m_tdata[35:27] <= 9'd256))
    else $error("alert strength above full scale");

  // The sets cover every input, so some rule always fires
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[35:0] != 36'd0))
    else $error("no alert strength on a valid result");

  // Backpressure reaches the input only when every stage is full and stalled
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the result side can move");
`endif

endmodule
